>>> hdl/fcrt_pkg.sv
`default_nettype none
package fcrt_pkg;

  localparam int unsigned SnapBytesDefault = 4;
  localparam int unsigned MaxSnapBytes     = 4;
  localparam int unsigned CfgDataWidth     = 40;
  localparam int unsigned CfgIndexWidth    = 3;
  localparam int unsigned TicksPerSecond   = 10;

  localparam logic [7:0] SensorErrorByte = 8'h80;

  // register reset values
  localparam logic [11:0] HeatingMinReset    = 12'd290;
  localparam logic [11:0] CoolingMaxReset    = 12'd250;
  localparam logic [11:0] HeatAutoMinReset   = 12'd160;
  localparam logic [10:0] HysteresisReset    = 11'd10;
  localparam logic [15:0] OffDelayReset      = 16'd300;
  localparam logic [19:0] ModeFieldsReset    = 20'd28701;
  localparam logic [39:0] ModeCodesReset     = 40'd21542076676;

  typedef enum logic [1:0] {
    OP_FAN       = 2'd0,
    OP_COOL      = 2'd1,
    OP_HEAT_AUTO = 2'd2,
    OP_HEAT      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SNAP   = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_HEATING_MIN   = 3'd0,
    CFG_COOLING_MAX   = 3'd1,
    CFG_HEAT_AUTO_MIN = 3'd2,
    CFG_HYSTERESIS    = 3'd3,
    CFG_OFF_DELAY     = 3'd4,
    CFG_MODE_FIELDS   = 3'd5,
    CFG_MODE_CODES    = 3'd6,
    CFG_NONE          = 3'd7
  } cfg_index_e;

endpackage
`default_nettype wire

>>> hdl/fcrt_in_if.sv
`default_nettype none
interface fcrt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         snap_byte0;
  logic [7:0]         snap_byte1;
  logic [7:0]         snap_byte2;
  logic [7:0]         snap_byte3;
  logic signed [15:0] sample;

  modport source (
    output valid, kind, snap_byte0, snap_byte1, snap_byte2, snap_byte3, sample,
    input  ready
  );
  modport sink (
    input  valid, kind, snap_byte0, snap_byte1, snap_byte2, snap_byte3, sample,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/fcrt_out_if.sv
`default_nettype none
interface fcrt_out_if;
  logic        valid;
  logic        ready;
  logic        relay_drive;
  logic [1:0]  mode_now;
  logic        sample_seen;
  logic        sensor_fault;
  logic [15:0] delay_left;

  modport source (
    output valid, relay_drive, mode_now, sample_seen, sensor_fault, delay_left,
    input  ready
  );
  modport sink (
    input  valid, relay_drive, mode_now, sample_seen, sensor_fault, delay_left,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/fan_coil_relay_thermostat.sv
// Fan-coil relay thermostat: bang-bang relay control with hysteresis and a
// minimum on time.
// in_ch carries one transaction per item: a 0.1 s tick, a mode snapshot of up
// to four bytes, or a pipe temperature sample. out_ch returns exactly one
// transaction per input: relay drive, decoded mode, stored-sample flag, sensor
// fault flag for this item and the seconds left of the off-delay.
// The result is loaded into the output register at the accepting edge.
// Throughput is one item per cycle while out_ch is not stalled; the state
// update and relay decision are a single pass of compares and a 17-bit
// threshold add and subtract.
// If out_ch stalls, the result holds and in_ch.ready stays low until the held
// result is taken; a new item can enter in the cycle the old result leaves.
// Reset puts the block in fan mode with the relay off, no sample stored and the
// off-delay cleared; registers take their documented defaults. Configuration is
// a plain write port (cfg_we_i, cfg_index_i, cfg_data_i), written by the user
// only while the block is idle (not enforced); unknown indexes are ignored.
`default_nettype none
module fan_coil_relay_thermostat #(
  parameter int unsigned SNAP_BYTES = fcrt_pkg::SnapBytesDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  fcrt_in_if.sink                                 in_ch,
  fcrt_out_if.source                              out_ch,
  input  wire logic                               cfg_we_i,
  input  wire logic [fcrt_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [fcrt_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  // configuration registers
  logic [11:0] heating_min_q;
  logic [11:0] cooling_max_q;
  logic [11:0] heat_auto_min_q;
  logic [10:0] hysteresis_q;
  logic [15:0] off_delay_q;
  logic [19:0] mode_fields_q;
  logic [39:0] mode_codes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heating_min_q   <= fcrt_pkg::HeatingMinReset;
      cooling_max_q   <= fcrt_pkg::CoolingMaxReset;
      heat_auto_min_q <= fcrt_pkg::HeatAutoMinReset;
      hysteresis_q    <= fcrt_pkg::HysteresisReset;
      off_delay_q     <= fcrt_pkg::OffDelayReset;
      mode_fields_q   <= fcrt_pkg::ModeFieldsReset;
      mode_codes_q    <= fcrt_pkg::ModeCodesReset;
    end else if (cfg_we_i) begin
      unique case (fcrt_pkg::cfg_index_e'(cfg_index_i))
        fcrt_pkg::CFG_HEATING_MIN:   heating_min_q   <= cfg_data_i[11:0];
        fcrt_pkg::CFG_COOLING_MAX:   cooling_max_q   <= cfg_data_i[11:0];
        fcrt_pkg::CFG_HEAT_AUTO_MIN: heat_auto_min_q <= cfg_data_i[11:0];
        fcrt_pkg::CFG_HYSTERESIS:    hysteresis_q    <= cfg_data_i[10:0];
        fcrt_pkg::CFG_OFF_DELAY:     off_delay_q     <= cfg_data_i[15:0];
        fcrt_pkg::CFG_MODE_FIELDS:   mode_fields_q   <= cfg_data_i[19:0];
        fcrt_pkg::CFG_MODE_CODES:    mode_codes_q    <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  // controller state
  logic [3:0]           tenth_q;
  logic [15:0]          delay_q;
  fcrt_pkg::mode_e      mode_q;
  logic signed [15:0]   temp_q;
  logic                 stored_q;
  logic                 relay_q;

  // output register
  logic                 out_valid_q;
  logic                 out_relay_q;
  fcrt_pkg::mode_e      out_mode_q;
  logic                 out_seen_q;
  logic                 out_fault_q;
  logic [15:0]          out_delay_q;

  logic accept;
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // snapshot decode
  logic [fcrt_pkg::MaxSnapBytes-1:0][7:0] snap;
  logic [1:0] idx1, idx2;
  logic [7:0] byte1, byte2, m1, m2;
  fcrt_pkg::mode_e mode_dec;

  assign snap = {in_ch.snap_byte3, in_ch.snap_byte2, in_ch.snap_byte1, in_ch.snap_byte0};
  assign idx1 = mode_fields_q[1:0];
  assign idx2 = mode_fields_q[11:10];

  always_comb begin
    byte1 = (32'(idx1) < SNAP_BYTES) ? snap[idx1] : 8'd0;
    byte2 = (32'(idx2) < SNAP_BYTES) ? snap[idx2] : 8'd0;
    m1    = byte1 & mode_fields_q[9:2];
    m2    = byte2 & mode_fields_q[19:12];
    if (m1 == mode_codes_q[31:24] && m2 == mode_codes_q[39:32]) begin
      mode_dec = fcrt_pkg::OP_HEAT_AUTO;
    end else if (m1 == mode_codes_q[7:0]) begin
      mode_dec = fcrt_pkg::OP_HEAT;
    end else if (m1 == mode_codes_q[15:8] || m1 == mode_codes_q[23:16]) begin
      mode_dec = fcrt_pkg::OP_COOL;
    end else begin
      mode_dec = fcrt_pkg::OP_FAN;
    end
  end

  // item update followed by relay decision
  logic [3:0]         tenth_inc;
  logic [3:0]         tenth_d;
  logic [15:0]        delay_mid, delay_d;
  fcrt_pkg::mode_e    mode_d;
  logic signed [15:0] temp_d;
  logic               stored_d;
  logic               relay_d;
  logic               fault_d;
  logic signed [16:0] t_ext, th_ext, h_ext, th_cool_on, th_heat_on;
  logic               on_cond, off_cond;

  assign tenth_inc = tenth_q + 4'd1;

  always_comb begin
    tenth_d   = tenth_q;
    delay_mid = delay_q;
    mode_d    = mode_q;
    temp_d    = temp_q;
    stored_d  = stored_q;
    fault_d   = 1'b0;
    case (fcrt_pkg::kind_e'(in_ch.kind))
      fcrt_pkg::KIND_TICK: begin
        tenth_d = tenth_inc;
        if (32'(tenth_inc) >= fcrt_pkg::TicksPerSecond) begin
          tenth_d = 4'd0;
          if (delay_q != 16'd0) delay_mid = delay_q - 16'd1;
        end
      end
      fcrt_pkg::KIND_SNAP: begin
        if (mode_dec != mode_q) begin
          delay_mid = 16'd0;
          mode_d    = mode_dec;
        end
      end
      fcrt_pkg::KIND_SAMPLE: begin
        if (in_ch.sample[15:8] == fcrt_pkg::SensorErrorByte) begin
          fault_d = 1'b1;
        end else begin
          temp_d   = in_ch.sample;
          stored_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    t_ext      = 17'(temp_d);
    h_ext      = 17'(signed'({1'b0, hysteresis_q}));
    th_ext     = (mode_d == fcrt_pkg::OP_COOL) ? 17'(signed'(cooling_max_q))
               : (mode_d == fcrt_pkg::OP_HEAT) ? 17'(signed'(heating_min_q))
               : 17'(signed'(heat_auto_min_q));
    th_cool_on = th_ext - h_ext;
    th_heat_on = th_ext + h_ext;
    if (mode_d == fcrt_pkg::OP_COOL) begin
      on_cond  = t_ext <= th_cool_on;
      off_cond = t_ext > th_ext;
    end else begin
      on_cond  = t_ext >= th_heat_on;
      off_cond = t_ext < th_ext;
    end

    relay_d = relay_q;
    delay_d = delay_mid;
    if (mode_d == fcrt_pkg::OP_FAN) begin
      relay_d = 1'b1;
    end else if (stored_d) begin
      if (on_cond) begin
        // turning on loads the minimum on time
        if (!relay_q) delay_d = off_delay_q;
        relay_d = 1'b1;
      end else if (off_cond && delay_mid == 16'd0) begin
        relay_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tenth_q     <= 4'd0;
      delay_q     <= 16'd0;
      mode_q      <= fcrt_pkg::OP_FAN;
      temp_q      <= 16'sd0;
      stored_q    <= 1'b0;
      relay_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        tenth_q  <= tenth_d;
        delay_q  <= delay_d;
        mode_q   <= mode_d;
        temp_q   <= temp_d;
        stored_q <= stored_d;
        relay_q  <= relay_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_relay_q <= relay_d;
      out_mode_q  <= mode_d;
      out_seen_q  <= stored_d;
      out_fault_q <= fault_d;
      out_delay_q <= delay_d;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.relay_drive  = out_relay_q;
  assign out_ch.mode_now     = out_mode_q;
  assign out_ch.sample_seen  = out_seen_q;
  assign out_ch.sensor_fault = out_fault_q;
  assign out_ch.delay_left   = out_delay_q;

endmodule
`default_nettype wire

>>> sim/fan_coil_relay_thermostat_test.sv
`timescale 1ns / 1ps

module fan_coil_relay_thermostat_test;

  typedef struct packed {
    fcrt_pkg::kind_e  kind;
    logic [3:0][7:0]  snap;
    logic [15:0]      sample;
  } thermo_item_t;

  typedef struct packed {
    logic            relay_drive;
    fcrt_pkg::mode_e mode_now;
    logic            sample_seen;
    logic            sensor_fault;
    logic [15:0]     delay_left;
  } relay_status_t;

  // tracks the thermostat state and the status words still owed by the block
  class relay_tracker;
    relay_status_t      awaited_q[$];
    int unsigned        errors;

    logic signed [11:0] heat_min;
    logic signed [11:0] cool_max;
    logic signed [11:0] auto_min;
    logic [10:0]        hyst;
    logic [15:0]        delay_load;
    logic [19:0]        fields;
    logic [39:0]        codes;

    logic [3:0]         tenths;
    logic [15:0]        delay_cnt;
    fcrt_pkg::mode_e    mode;
    logic signed [15:0] pipe;
    bit                 have_temp;
    bit                 relay;

    function new();
      heat_min   = fcrt_pkg::HeatingMinReset;
      cool_max   = fcrt_pkg::CoolingMaxReset;
      auto_min   = fcrt_pkg::HeatAutoMinReset;
      hyst       = fcrt_pkg::HysteresisReset;
      delay_load = fcrt_pkg::OffDelayReset;
      fields     = fcrt_pkg::ModeFieldsReset;
      codes      = fcrt_pkg::ModeCodesReset;
      tenths     = '0;
      delay_cnt  = '0;
      mode       = fcrt_pkg::OP_FAN;
      pipe       = '0;
      have_temp  = 1'b0;
      relay      = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(fcrt_pkg::cfg_index_e idx, logic [39:0] value);
      case (idx)
        fcrt_pkg::CFG_HEATING_MIN:   heat_min   = value[11:0];
        fcrt_pkg::CFG_COOLING_MAX:   cool_max   = value[11:0];
        fcrt_pkg::CFG_HEAT_AUTO_MIN: auto_min   = value[11:0];
        fcrt_pkg::CFG_HYSTERESIS:    hyst       = value[10:0];
        fcrt_pkg::CFG_OFF_DELAY:     delay_load = value[15:0];
        fcrt_pkg::CFG_MODE_FIELDS:   fields     = value[19:0];
        fcrt_pkg::CFG_MODE_CODES:    codes      = value;
        default: ;
      endcase
    endfunction

    function fcrt_pkg::mode_e decode_snapshot(thermo_item_t it);
      logic [7:0] m1;
      logic [7:0] m2;
      m1 = it.snap[fields[1:0]] & fields[9:2];
      m2 = it.snap[fields[11:10]] & fields[19:12];
      if (m1 == codes[31:24] && m2 == codes[39:32]) return fcrt_pkg::OP_HEAT_AUTO;
      if (m1 == codes[7:0]) return fcrt_pkg::OP_HEAT;
      if (m1 == codes[15:8] || m1 == codes[23:16]) return fcrt_pkg::OP_COOL;
      return fcrt_pkg::OP_FAN;
    endfunction

    function void settle_relay();
      int t;
      int th;
      int h;
      bit turn_on;
      bit turn_off;
      if (mode == fcrt_pkg::OP_FAN) begin
        relay = 1'b1;
        return;
      end
      if (!have_temp) return;
      t = pipe;
      h = hyst;
      if (mode == fcrt_pkg::OP_COOL) begin
        th = cool_max;
        turn_on  = t <= th - h;
        turn_off = t > th;
      end else begin
        th = (mode == fcrt_pkg::OP_HEAT) ? heat_min : auto_min;
        turn_on  = t >= th + h;
        turn_off = t < th;
      end
      if (turn_on) begin
        if (!relay) delay_cnt = delay_load;
        relay = 1'b1;
      end else if (turn_off && delay_cnt == 0) begin
        relay = 1'b0;
      end
    endfunction

    function void note_item(thermo_item_t it);
      relay_status_t   st;
      fcrt_pkg::mode_e m;
      bit              fault;
      fault = 1'b0;
      case (it.kind)
        fcrt_pkg::KIND_TICK: begin
          tenths = tenths + 1'b1;
          if (tenths >= fcrt_pkg::TicksPerSecond) begin
            tenths = '0;
            if (delay_cnt != 0) delay_cnt = delay_cnt - 1'b1;
          end
        end
        fcrt_pkg::KIND_SNAP: begin
          m = decode_snapshot(it);
          if (m != mode) begin
            delay_cnt = '0;
            mode = m;
          end
        end
        fcrt_pkg::KIND_SAMPLE: begin
          if (it.sample[15:8] == fcrt_pkg::SensorErrorByte) begin
            fault = 1'b1;
          end else begin
            pipe = it.sample;
            have_temp = 1'b1;
          end
        end
        default: ;
      endcase
      settle_relay();
      st.relay_drive  = relay;
      st.mode_now     = mode;
      st.sample_seen  = have_temp;
      st.sensor_fault = fault;
      st.delay_left   = delay_cnt;
      awaited_q.push_back(st);
    endfunction

    function void check_output(relay_status_t got);
      relay_status_t want;
      if (awaited_q.size() == 0) begin
        $error("status transaction with nothing pending");
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      if (got.relay_drive !== want.relay_drive) begin
        $error("relay_drive: expected %0d, got %0d", want.relay_drive, got.relay_drive);
        errors++;
      end
      if (got.mode_now !== want.mode_now) begin
        $error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
        errors++;
      end
      if (got.sample_seen !== want.sample_seen) begin
        $error("sample_seen: expected %0d, got %0d", want.sample_seen, got.sample_seen);
        errors++;
      end
      if (got.sensor_fault !== want.sensor_fault) begin
        $error("sensor_fault: expected %0d, got %0d", want.sensor_fault, got.sensor_fault);
        errors++;
      end
      if (got.delay_left !== want.delay_left) begin
        $error("delay_left: expected %0d, got %0d", want.delay_left, got.delay_left);
        errors++;
      end
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [fcrt_pkg::CfgIndexWidth-1:0] cfg_index_i;
  logic [fcrt_pkg::CfgDataWidth-1:0]  cfg_data_i;
  bit                                 hold_rx;
  bit                                 quiet_phase;

  relay_tracker board = new();

  fcrt_in_if  in_ch();
  fcrt_out_if out_ch();

  fan_coil_relay_thermostat u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("** fan_coil_relay_thermostat: FAILED **");
    $finish;
  end

  function automatic thermo_item_t plain_item(fcrt_pkg::kind_e k);
    thermo_item_t it;
    it.kind   = k;
    it.snap   = $urandom;
    it.sample = 16'($urandom);
    return it;
  endfunction

  function automatic thermo_item_t snap_item(logic [7:0] b0, logic [7:0] b1,
                                             logic [7:0] b2, logic [7:0] b3);
    thermo_item_t it;
    it = plain_item(fcrt_pkg::KIND_SNAP);
    it.snap = {b3, b2, b1, b0};
    return it;
  endfunction

  function automatic thermo_item_t sample_item(logic [15:0] s);
    thermo_item_t it;
    it = plain_item(fcrt_pkg::KIND_SAMPLE);
    it.sample = s;
    return it;
  endfunction

  function automatic void place_code(inout thermo_item_t it, input logic [1:0] idx,
                                     input logic [7:0] mask, input logic [7:0] code);
    it.snap[idx] = (it.snap[idx] & ~mask) | (code & mask);
  endfunction

  // mostly ticks, then samples mostly around the live threshold and snapshots that often hit a mode
  function automatic thermo_item_t random_item();
    thermo_item_t it;
    int unsigned  pick;
    int           th;
    int           h;
    int           lo;
    int           hi;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it = plain_item(fcrt_pkg::KIND_TICK);
    end else if (pick < 60) begin
      it = plain_item(fcrt_pkg::KIND_SNAP);
      if ($urandom_range(0, 9) < 7) begin
        case (fcrt_pkg::mode_e'($urandom_range(0, 3)))
          fcrt_pkg::OP_HEAT:
            place_code(it, board.fields[1:0], board.fields[9:2], board.codes[7:0]);
          fcrt_pkg::OP_COOL:
            place_code(it, board.fields[1:0], board.fields[9:2],
                       $urandom_range(0, 1) ? board.codes[15:8] : board.codes[23:16]);
          fcrt_pkg::OP_HEAT_AUTO: begin
            place_code(it, board.fields[1:0], board.fields[9:2], board.codes[31:24]);
            place_code(it, board.fields[11:10], board.fields[19:12], board.codes[39:32]);
          end
          default: ;
        endcase
      end
    end else if (pick < 95) begin
      it = plain_item(fcrt_pkg::KIND_SAMPLE);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        it.sample[15:8] = fcrt_pkg::SensorErrorByte;
      end else if (pick >= 25) begin
        h = board.hyst;
        case (board.mode)
          fcrt_pkg::OP_COOL: th = board.cool_max;
          fcrt_pkg::OP_HEAT: th = board.heat_min;
          default:           th = board.auto_min;
        endcase
        if (board.mode == fcrt_pkg::OP_COOL) begin
          lo = th - h - 4;
          hi = th + 4;
        end else begin
          lo = th - 4;
          hi = th + h + 4;
        end
        it.sample = 16'(lo + int'($urandom_range(0, hi - lo)));
      end
    end else begin
      it = plain_item(fcrt_pkg::KIND_UNUSED);
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(thermo_item_t it);
    in_ch.kind       = it.kind;
    in_ch.snap_byte0 = it.snap[0];
    in_ch.snap_byte1 = it.snap[1];
    in_ch.snap_byte2 = it.snap[2];
    in_ch.snap_byte3 = it.snap[3];
    in_ch.sample     = it.sample;
    in_ch.valid      = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic write_reg(fcrt_pkg::cfg_index_e idx, logic [39:0] value);
    cfg_index_i = idx;
    cfg_data_i  = value;
    cfg_we_i    = 1'b1;
    @(posedge clk_i);
    board.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (board.awaited_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic program_phase(int phase);
    logic signed [11:0] hm;
    logic signed [11:0] cm;
    logic signed [11:0] am;
    logic [10:0]        hy;
    logic [15:0]        od;
    logic [19:0]        mf;
    logic [39:0]        mc;
    mf = 20'($urandom);
    mc = 40'({$urandom, $urandom});
    case (phase)
      1: begin
        hm = -12'sd2000;
        cm = -12'sd2000;
        am = -12'sd2000;
        hy = 11'd0;
        od = 16'd0;
      end
      2: begin
        hm = 12'sd2000;
        cm = 12'sd2000;
        am = 12'sd2000;
        hy = 11'd2000;
        od = 16'hffff;
      end
      default: begin
        hm = 12'(int'($urandom_range(0, 4000)) - 2000);
        cm = 12'(int'($urandom_range(0, 4000)) - 2000);
        am = 12'(int'($urandom_range(0, 4000)) - 2000);
        hy = 11'($urandom_range(0, 60));
        od = (phase == 4) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 4));
      end
    endcase
    // keep the codes reachable through the masks most of the time
    if (phase != 5) begin
      mc[7:0]   = mc[7:0] & mf[9:2];
      mc[15:8]  = mc[15:8] & mf[9:2];
      mc[23:16] = mc[23:16] & mf[9:2];
      mc[31:24] = mc[31:24] & mf[9:2];
      mc[39:32] = mc[39:32] & mf[19:12];
    end
    write_reg(fcrt_pkg::CFG_HEATING_MIN, {28'd0, hm});
    write_reg(fcrt_pkg::CFG_COOLING_MAX, {28'd0, cm});
    write_reg(fcrt_pkg::CFG_HEAT_AUTO_MIN, {28'd0, am});
    write_reg(fcrt_pkg::CFG_HYSTERESIS, {29'd0, hy});
    write_reg(fcrt_pkg::CFG_OFF_DELAY, {24'd0, od});
    write_reg(fcrt_pkg::CFG_MODE_FIELDS, {20'd0, mf});
    write_reg(fcrt_pkg::CFG_MODE_CODES, mc);
    write_reg(fcrt_pkg::CFG_NONE, 40'({$urandom, $urandom}));
    cfg_we_i = 1'b0;
  endtask

  // receiver: random stalls, quiet stretches and one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        out_ch.ready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_rx = 1'b0;
      end else begin
        out_ch.ready = quiet_phase || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  always @(posedge clk_i) begin
    relay_status_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.relay_drive  = out_ch.relay_drive;
      got.mode_now     = fcrt_pkg::mode_e'(out_ch.mode_now);
      got.sample_seen  = out_ch.sample_seen;
      got.sensor_fault = out_ch.sensor_fault;
      got.delay_left   = out_ch.delay_left;
      board.check_output(got);
    end
  end

  initial begin
    thermo_item_t directed_q[$];
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = fcrt_pkg::CFG_NONE;
    cfg_data_i       = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = fcrt_pkg::KIND_TICK;
    in_ch.snap_byte0 = '0;
    in_ch.snap_byte1 = '0;
    in_ch.snap_byte2 = '0;
    in_ch.snap_byte3 = '0;
    in_ch.sample     = '0;
    hold_rx          = 1'b0;
    quiet_phase      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: mode byte 1 and byte 0 under mask 7, heat 4, cool 1,
    // dry 2, heat auto 4 with 5
    repeat (10) directed_q.push_back(plain_item(fcrt_pkg::KIND_TICK));  // delay already zero
    directed_q.push_back(plain_item(fcrt_pkg::KIND_UNUSED));
    directed_q.push_back(sample_item(16'h8000));
    directed_q.push_back(sample_item(16'h80ff));
    directed_q.push_back(snap_item(8'h00, 8'h04, 8'h00, 8'h00));  // heat, nothing stored
    directed_q.push_back(sample_item(16'd0));
    directed_q.push_back(sample_item(16'd300));
    directed_q.push_back(sample_item(16'h7fff));
    directed_q.push_back(sample_item(16'h8100));  // below threshold, delay running
    directed_q.push_back(snap_item(8'h05, 8'h04, 8'hff, 8'hff));  // heat auto
    directed_q.push_back(sample_item(16'd170));
    directed_q.push_back(snap_item(8'h00, 8'h01, 8'h00, 8'h00));  // cool
    directed_q.push_back(sample_item(16'hffff));
    directed_q.push_back(sample_item(16'h7f00));
    directed_q.push_back(snap_item(8'h00, 8'h02, 8'h00, 8'h00));  // dry decodes as cool
    directed_q.push_back(sample_item(16'd240));
    directed_q.push_back(snap_item(8'hff, 8'hff, 8'hff, 8'hff));  // fan
    directed_q.push_back(snap_item(8'h00, 8'h00, 8'h00, 8'h00));
    directed_q.push_back(plain_item(fcrt_pkg::KIND_UNUSED));
    foreach (directed_q[i]) send_item(directed_q[i]);
    drain();

    for (int phase = 1; phase <= 5; phase++) begin
      program_phase(phase);
      quiet_phase = (phase == 3);
      if (phase == 2) hold_rx = 1'b1;
      repeat (260) begin
        if (!quiet_phase && $urandom_range(0, 99) < 8) begin
          in_ch.valid = 1'b0;
          repeat ($urandom_range(1, 4)) @(negedge clk_i);
        end
        send_item(random_item());
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (board.errors == 0 && board.awaited_q.size() == 0) begin
      $display("** fan_coil_relay_thermostat: PASSED **");
    end else begin
      $display("** fan_coil_relay_thermostat: FAILED **");
    end
    $finish;
  end

endmodule
